>>> sv/rmf_pkg.sv
// Shared types, constants and helpers for the running median filter.
package rmf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int HIST_DEPTH  = 6;
  // Largest even count of earlier samples that fits in the history.
  localparam int HIST_FIT    = (HIST_DEPTH / 2) * 2;
  localparam int WIN_LEN     = HIST_FIT + 1;
  localparam int MID_RANK    = HIST_FIT / 2;
  localparam int CNT_BITS    = $clog2(WIN_LEN + 1);
  localparam int MODE_BITS   = 2;
  localparam int PREV_BITS   = 3;

  localparam logic [MODE_BITS-1:0] MODE_3 = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_5 = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_7 = 2'd2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [WIN_LEN-1:0][SAMPLE_BITS-1:0] window_t;
  typedef logic [WIN_LEN-1:0][WIN_LEN-1:0] cmp_mat_t;

  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};

  // Stage advance strobes handed from the top level to the selection pipeline.
  typedef struct packed {
    logic adv_cmp;
    logic adv_out;
  } rmf_ctl_t;

  // Number of earlier samples that join the window for a given mode.
  function automatic logic [PREV_BITS-1:0] prev_count(input logic [MODE_BITS-1:0] mode);
    logic [PREV_BITS-1:0] p;
    case (mode)
      MODE_3:  p = 3'd2;
      MODE_5:  p = 3'd4;
      MODE_7:  p = 3'd6;
      default: p = 3'd6;
    endcase
    if (p > PREV_BITS'(HIST_FIT)) begin
      p = PREV_BITS'(HIST_FIT);
    end
    return p;
  endfunction

endpackage

>>> sv/rmf_cell.sv
// One history cell: holds a raw sample and passes it down the chain.
module rmf_cell (
  input  logic             clk,
  input  logic             fill,
  input  logic             shift,
  input  rmf_pkg::sample_t fill_in,
  input  rmf_pkg::sample_t shift_in,
  output rmf_pkg::sample_t q
);
  import rmf_pkg::*;

  sample_t held;

  always_ff @(posedge clk) begin
    if (fill) begin
      held <= fill_in;
    end else if (shift) begin
      held <= shift_in;
    end
  end

  assign q = held;

endmodule

>>> sv/rmf_select.sv
// Median selection: a stage of pairwise compares, then rank counting into the output register.
module rmf_select (
  input  logic              clk,
  input  rmf_pkg::rmf_ctl_t ctl,
  input  rmf_pkg::window_t  win,
  output rmf_pkg::sample_t  median
);
  import rmf_pkg::*;

  window_t  win2;
  cmp_mat_t lt2;
  cmp_mat_t eq2;
  cmp_mat_t lt_next;
  cmp_mat_t eq_next;
  sample_t  pick;
  sample_t  median_reg;

  // Every pair is compared independently; row i says which entries lie below or at entry i.
  always_comb begin
    for (int i = 0; i < WIN_LEN; i++) begin
      for (int j = 0; j < WIN_LEN; j++) begin
        lt_next[i][j] = $signed(win[j]) < $signed(win[i]);
        eq_next[i][j] = win[j] == win[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_cmp) begin
      win2 <= win;
      lt2  <= lt_next;
      eq2  <= eq_next;
    end
  end

  // An entry is the median when the middle rank falls within its run of equal values.
  always_comb begin
    logic [CNT_BITS-1:0] below;
    logic [CNT_BITS-1:0] same;
    pick = win2[0];
    for (int i = WIN_LEN - 1; i >= 0; i--) begin
      below = CNT_BITS'($countones(lt2[i]));
      same  = CNT_BITS'($countones(eq2[i]));
      if (below <= CNT_BITS'(MID_RANK) && CNT_BITS'(MID_RANK) < below + same) begin
        pick = win2[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_out) begin
      median_reg <= pick;
    end
  end

  assign median = median_reg;

endmodule

>>> sv/running_median_filter.sv
// Top level of the running median filter with 3, 5 or 7 sample windows.
//
// Each input word carries one signed sample; each output word carries the
// median of that sample and the 2, 4 or 6 raw samples before it, as chosen
// by window_mode (0, 1 or 2; code 3 acts as 2). The history is a chain of
// six cells that shift on every accepted word and always hold raw inputs.
// The first word after reset or after any write to window_mode fills every
// cell with its sample and is passed through as its own median. Throughput
// is one word per clock cycle while the output is not stalled. Each word is
// latched into the window register, then into the pairwise compare matrix,
// and then rank counted into the output register. Shorter windows are padded
// with equal numbers of minimum and maximum values so that the same
// seven-entry selection serves every mode. Each stage only waits when the
// stage after it is full and stalled, so new words are taken while a
// finished median waits at the output. Write window_mode only while no word
// is in flight.
module running_median_filter (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration: window_mode.
  input  logic                                 cfg_we,
  input  logic [rmf_pkg::MODE_BITS-1:0]        cfg_data,
  // Input stream. s_tdata: sample in bits 15:0.
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [rmf_pkg::TDATA_BITS-1:0]       s_tdata,
  // Output stream. m_tdata: median in bits 15:0.
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [rmf_pkg::TDATA_BITS-1:0]       m_tdata
);
  import rmf_pkg::*;

  logic [MODE_BITS-1:0] window_mode;
  logic                 primed;
  logic                 accept;
  logic                 fill;
  logic                 shift;
  sample_t              sample;
  sample_t              hist [HIST_DEPTH];
  logic [PREV_BITS-1:0] prev;
  window_t              win_next;
  window_t              win1;
  logic                 v1;
  logic                 v2;
  logic                 v3;
  logic                 en1;
  logic                 en2;
  logic                 en3;
  rmf_ctl_t             ctl;
  sample_t              median;

  assign sample = s_tdata[SAMPLE_BITS-1:0];

  // Each stage may advance when it is empty or the stage after it advances.
  assign en3      = !v3 || m_tready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;
  assign accept   = s_tvalid && s_tready;
  assign fill     = accept && !primed;
  assign shift    = accept && primed;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_mode <= MODE_3;
      primed      <= 1'b0;
    end else if (cfg_we) begin
      window_mode <= cfg_data;
      primed      <= 1'b0;
    end else if (accept) begin
      primed <= 1'b1;
    end
  end

  // History chain: cell 0 takes the new sample, each later cell takes its neighbor.
  for (genvar g = 0; g < HIST_DEPTH; g++) begin : g_cell
    rmf_cell u_cell (
      .clk      (clk),
      .fill     (fill),
      .shift    (shift),
      .fill_in  (sample),
      .shift_in ((g == 0) ? sample : hist[(g == 0) ? 0 : g - 1]),
      .q        (hist[g])
    );
  end

  assign prev = prev_count(window_mode);

  // Build the window. Entries beyond the selected length alternate between
  // the smallest and largest values, which leaves the median unchanged.
  // While unprimed every entry is the sample itself.
  always_comb begin
    win_next[0] = sample;
    for (int i = 1; i < WIN_LEN; i++) begin
      if (!primed) begin
        win_next[i] = sample;
      end else if (i <= int'(prev)) begin
        win_next[i] = hist[i - 1];
      end else if (((i - int'(prev)) % 2) == 1) begin
        win_next[i] = SAMPLE_MIN;
      end else begin
        win_next[i] = SAMPLE_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && accept) begin
      win1 <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= accept;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  assign ctl.adv_cmp = en2;
  assign ctl.adv_out = en3;

  rmf_select u_select (
    .clk    (clk),
    .ctl    (ctl),
    .win    (win1),
    .median (median)
  );

  assign m_tvalid = v3;
  assign m_tdata  = TDATA_BITS'($unsigned(median));

endmodule

>>> sv/rmf_checker.sv
// Port-level checks for the running median filter, bound to the top level.
module rmf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [rmf_pkg::TDATA_BITS-1:0] m_tdata
);
  import rmf_pkg::*;

  // A stalled output word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // An empty output stage never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  // An accepted word reaches the output, or waits behind a word that did.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> ##3 m_tvalid)
    else $error("accepted word did not reach the output");

endmodule

bind running_median_filter rmf_checker u_rmf_checker (.*);

>>> test/testbench.sv
// Self-checking testbench for the running median filter with 3, 5 and 7 sample windows.
module testbench;
  import rmf_pkg::*;

  // Unused window code; the block treats it as the seven sample window.
  localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;
  // Cycles to let pass after the last median before touching window_mode.
  localparam int SETTLE_CYCLES = 8;
  // Cycles without any accepted word before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [MODE_BITS-1:0]  cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [TDATA_BITS-1:0] s_tdata;   // sample in bits 15:0
  logic                  m_tvalid;
  logic                  m_tready;
  logic [TDATA_BITS-1:0] m_tdata;   // median in bits 15:0

  // Predictor state: raw sample history, newest first, and the priming flag.
  sample_t              hist [HIST_DEPTH];
  logic                 primed;
  logic [MODE_BITS-1:0] win_mode;

  // Medians predicted for accepted samples, oldest first.
  sample_t median_q [$];

  int err_count;
  int quiet_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int hold_left;

  running_median_filter u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Advances the predictor by one raw sample and returns the expected median.
  // The window is the new sample plus the newest 2, 4 or 6 history entries;
  // it is sorted and the middle entry taken.
  function automatic sample_t filter_step(input sample_t s);
    sample_t win [0:HIST_DEPTH];
    sample_t key;
    sample_t mid;
    int taps;
    int i;
    int j;
    if (!primed) begin
      // First sample after reset or a window write fills the whole history.
      for (i = 0; i < HIST_DEPTH; i++) hist[i] = s;
      primed = 1'b1;
      return s;
    end
    case (win_mode)
      MODE_3: begin
        taps = 2;
      end
      MODE_5: begin
        taps = 4;
      end
      default: begin
        taps = 6;
      end
    endcase
    if (taps > (HIST_DEPTH / 2) * 2) taps = (HIST_DEPTH / 2) * 2;
    win[0] = s;
    for (i = 0; i < taps; i++) win[i + 1] = hist[i];
    for (i = 1; i <= taps; i++) begin
      key = win[i];
      j = i - 1;
      while (j >= 0 && win[j] > key) begin
        win[j + 1] = win[j];
        j--;
      end
      win[j + 1] = key;
    end
    mid = win[taps / 2];
    for (i = HIST_DEPTH - 1; i > 0; i--) hist[i] = hist[i - 1];
    hist[0] = s;
    return mid;
  endfunction

  // Mostly full-range samples, with clusters near zero to force ties and
  // a share of the two extremes.
  function automatic sample_t random_sample();
    sample_t s;
    case ($urandom_range(9))
      6, 7: begin
        s = sample_t'($signed($urandom_range(8)) - 4);
      end
      8: begin
        s = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      end
      default: begin
        s = sample_t'($urandom);
      end
    endcase
    return s;
  endfunction

  task automatic report_mismatch(input string what, input sample_t exp_v, input sample_t got_v);
    $display("mismatch at %0t: %s, expected %0d, got %0d", $realtime, what, exp_v, got_v);
    err_count++;
  endtask

  // Offers one sample word, with random idle cycles in front of it, and
  // records its expected median once the word is accepted.
  task automatic push_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_BITS'($unsigned(s));
    do @(posedge clk); while (!s_tready);
    median_q.push_back(filter_step(s));
  endtask

  // Stops offering words, waits for every median still owed and lets the
  // pipeline settle so that the block is idle afterwards.
  task automatic wait_for_medians();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes window_mode while the block is idle; the write also clears the
  // priming flag, so the next sample refills the history.
  task automatic set_window(input logic [MODE_BITS-1:0] mode);
    wait_for_medians();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    win_mode = mode;
    primed   = 1'b0;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Default window after reset, without any register write.
  task automatic test_reset_window();
    push_sample(16'sh1234);
    push_sample(-16'sd3);
    push_sample(16'sd7);
    push_sample(16'sd7);
    push_sample(SAMPLE_MIN);
  endtask

  // Every window code with extreme and repeated samples.
  task automatic test_window_codes();
    logic [MODE_BITS-1:0] codes [4];
    int k;
    codes = '{MODE_3, MODE_5, MODE_7, MODE_SPARE};
    for (k = 0; k < 4; k++) begin
      set_window(codes[k]);
      push_sample(SAMPLE_MIN);
      push_sample(SAMPLE_MAX);
      push_sample(SAMPLE_MAX);
      push_sample(16'sd0);
      push_sample(-16'sd1);
    end
  endtask

  // Random samples under one idling pattern, visiting every window code
  // starting from a random one.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int per_window);
    logic [MODE_BITS-1:0] codes [4];
    int first;
    int k;
    int n;
    codes = '{MODE_3, MODE_5, MODE_7, MODE_SPARE};
    first = $urandom_range(3);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (k = 0; k < 4; k++) begin
      set_window(codes[(first + k) % 4]);
      for (n = 0; n < per_window; n++) push_sample(random_sample());
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering words, so the pipeline fills and input backpressure shows.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_window(MODE_7);
    hold_request = HOLD_CYCLES;
    for (int n = 0; n < 60; n++) push_sample(random_sample());
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Each accepted median word is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (median_q.size() == 0) begin
        report_mismatch("median word with none expected", '0,
                        sample_t'(m_tdata[SAMPLE_BITS-1:0]));
      end else if (sample_t'(m_tdata[SAMPLE_BITS-1:0]) != median_q[0]) begin
        report_mismatch("median", median_q[0], sample_t'(m_tdata[SAMPLE_BITS-1:0]));
        void'(median_q.pop_front());
      end else begin
        void'(median_q.pop_front());
      end
    end
  end

  // Watchdog: a long run of cycles with no word moving on either side means
  // the block has hung.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_data       = MODE_3;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b0;
    err_count      = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    hold_left      = 0;
    primed         = 1'b0;
    win_mode       = MODE_3;
    for (int i = 0; i < HIST_DEPTH; i++) hist[i] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_window();
    test_window_codes();
    test_random_traffic(0, 0, 80);
    test_random_traffic(82, 0, 80);
    test_random_traffic(0, 82, 80);
    test_random_traffic(26, 26, 80);
    test_output_backpressure();
    wait_for_medians();

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/rmf_pkg.sv
sv/rmf_cell.sv
sv/rmf_select.sv
sv/running_median_filter.sv
sv/rmf_checker.sv
test/testbench.sv
